// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks, disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, constants and phase functions for the 4-bit character LCD interface.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

	// Request kinds
	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_INSTR = 2'd1,
		CMD_DATA  = 2'd2,
		CMD_LINE  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   command;
		logic [7:0]  value_byte;
		logic [1:0]  line_index;
	} req_t;

	typedef struct packed {
		logic [3:0]  data_nibble;
		logic        register_select;
		logic        enable_pin;
		logic [6:0]  hold_ms;
		logic        last_phase;
	} phase_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EMIT
	} ctl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_req;
		logic load_out;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_shown;
	} ctl_status_t;

	// Sequence geometry
	localparam int NIBBLE_PHASES   = 3;
	localparam int BYTE_PHASES     = 2 * NIBBLE_PHASES;
	localparam int INIT_NIBBLES    = 4;
	localparam int INIT_BYTES      = 4;
	localparam int INIT_FIRST_BYTE = 1 + INIT_NIBBLES * NIBBLE_PHASES;
	localparam int INIT_PHASES     = INIT_FIRST_BYTE + INIT_BYTES * BYTE_PHASES;
	localparam int STEP_W          = $clog2(INIT_PHASES);

	// Position of a phase inside one nibble write
	localparam logic [1:0] SUB_STROBE  = 2'd1;
	localparam logic [1:0] SUB_RELEASE = 2'd2;

	// Hold times in ms
	localparam logic [6:0] HOLD_BASE     = 7'd1;
	localparam logic [6:0] HOLD_POWER_UP = 7'd100;
	localparam logic [6:0] EXTRA_NONE    = 7'd0;
	localparam logic [6:0] EXTRA_SHORT   = 7'd1;
	localparam logic [6:0] EXTRA_LONG    = 7'd4;
	localparam logic [6:0] EXTRA_DATA    = 7'd1;
	localparam logic [6:0] EXTRA_SETTLE  = 7'd10;

	// Instructions below this take the long execution time
	localparam logic [7:0] SLOW_INSTR_LIMIT = 8'h04;
	localparam logic [7:0] SET_DDRAM        = 8'h80;

	localparam logic [7:0] LINE_START [4] = '{8'h00, 8'h40, 8'h10, 8'h50};
	localparam logic [7:0] INIT_BYTE  [INIT_BYTES] = '{8'h28, 8'h08, 8'h01, 8'h06};
	localparam logic [3:0] INIT_NIBBLE [INIT_NIBBLES] = '{4'h3, 4'h3, 4'h3, 4'h2};
	localparam logic [6:0] INIT_NIBBLE_EXTRA [INIT_NIBBLES] =
		'{7'd10, 7'd1, 7'd1, 7'd10};

	function automatic logic [6:0] instr_extra(input logic [7:0] b);
		return (b < SLOW_INSTR_LIMIT) ? EXTRA_LONG : EXTRA_SHORT;
	endfunction

	// One phase of a nibble write: setup, strobe, release
	function automatic phase_t nibble_phase(input logic [3:0] nib, input logic rs,
			input logic [1:0] sub, input logic [6:0] extra);
		phase_t p;
		p.data_nibble     = nib;
		p.register_select = rs;
		p.enable_pin      = (sub == SUB_STROBE);
		p.hold_ms         = (sub == SUB_RELEASE) ? 7'(HOLD_BASE + extra) : HOLD_BASE;
		p.last_phase      = 1'b0;
		return p;
	endfunction

	// One phase of a byte write: high nibble first, trailing delay on the last
	function automatic phase_t byte_phase(input logic [7:0] b, input logic rs,
			input logic [2:0] u, input logic [6:0] extra);
		phase_t p;
		if (u < 3'(NIBBLE_PHASES)) begin
			p = nibble_phase(b[7:4], rs, u[1:0], EXTRA_NONE);
		end else begin
			p = nibble_phase(b[3:0], rs, 2'(u - 3'(NIBBLE_PHASES)), extra);
		end
		return p;
	endfunction

	// Power-up sequence phase by step
	function automatic phase_t init_phase(input logic [STEP_W-1:0] s);
		phase_t p;
		logic [STEP_W-1:0] t;
		logic [1:0] k;
		logic [7:0] b;
		if (s == '0) begin
			p = '0;
			p.hold_ms = HOLD_POWER_UP;
		end else if (s < STEP_W'(INIT_FIRST_BYTE)) begin
			t = STEP_W'(s - 1'b1);
			k = (t >= STEP_W'(3 * NIBBLE_PHASES)) ? 2'd3 :
			    (t >= STEP_W'(2 * NIBBLE_PHASES)) ? 2'd2 :
			    (t >= STEP_W'(NIBBLE_PHASES))     ? 2'd1 : 2'd0;
			p = nibble_phase(INIT_NIBBLE[k], 1'b0,
				2'(t - STEP_W'(k) * STEP_W'(NIBBLE_PHASES)), INIT_NIBBLE_EXTRA[k]);
		end else begin
			t = STEP_W'(s - STEP_W'(INIT_FIRST_BYTE));
			k = (t >= STEP_W'(3 * BYTE_PHASES)) ? 2'd3 :
			    (t >= STEP_W'(2 * BYTE_PHASES)) ? 2'd2 :
			    (t >= STEP_W'(BYTE_PHASES))     ? 2'd1 : 2'd0;
			b = INIT_BYTE[k];
			p = byte_phase(b, 1'b0, 3'(t - STEP_W'(k) * STEP_W'(BYTE_PHASES)),
				7'(instr_extra(b) + EXTRA_SETTLE));
		end
		p.last_phase = (s == STEP_W'(INIT_PHASES - 1));
		return p;
	endfunction

	// Phase for any request kind at a given step
	function automatic phase_t phase_of(input req_t r, input logic [STEP_W-1:0] s);
		phase_t p;
		logic [7:0] b;
		b = SET_DDRAM | LINE_START[r.line_index];
		unique case (r.command)
			CMD_INIT:  p = init_phase(s);
			CMD_INSTR: p = byte_phase(r.value_byte, 1'b0, s[2:0], instr_extra(r.value_byte));
			CMD_DATA:  p = byte_phase(r.value_byte, 1'b1, s[2:0], EXTRA_DATA);
			CMD_LINE:  p = byte_phase(b, 1'b0, s[2:0], instr_extra(b));
			default:   p = '0;
		endcase
		if (r.command != CMD_INIT) begin
			p.last_phase = (s == STEP_W'(BYTE_PHASES - 1));
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// File: hdl/clcd_datapath.sv
// ----------------------------------------------------------------------------
// clcd_datapath
// Request register, phase step counter and output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_datapath import clcd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctl_cmd_t    cmd,
	input  wire req_t        req,
	output ctl_status_t      status,
	output phase_t           phase
);

	logic [STEP_W-1:0] step_q;
	req_t              req_q;
	phase_t            phase_q;

	// Clear the step on a new request, advance it per loaded word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load_req) begin
			step_q <= '0;
		end else if (cmd.load_out) begin
			step_q <= STEP_W'(step_q + 1'b1);
		end
	end

	// Hold the request and the word on show
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		if (cmd.load_out) begin
			phase_q <= phase_of(req_q, step_q);
		end
	end

	assign status.last_shown = phase_q.last_phase;
	assign phase             = phase_q;

endmodule

`default_nettype wire

// File: hdl/clcd_ctrl.sv
// ----------------------------------------------------------------------------
// clcd_ctrl
// Sequencer: takes one request, then steps words out until the last one goes.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_ctrl import clcd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	output logic             phase_valid,
	input  wire logic        phase_stall,
	output ctl_cmd_t         cmd,
	input  wire ctl_status_t status
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!phase_stall && status.last_shown) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: latch the request, load the next word when the current one goes
	always_comb begin
		req_stall    = 1'b1;
		phase_valid  = 1'b0;
		cmd.load_req = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall    = 1'b0;
				cmd.load_req = req_valid;
			end
			ST_LOAD: begin
				cmd.load_out = 1'b1;
			end
			ST_EMIT: begin
				phase_valid  = 1'b1;
				cmd.load_out = !phase_stall && !status.last_shown;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/char_lcd_nibble_interface.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface
// 4-bit character LCD driver: one request becomes a run of timed pin words.
// First word: the request is latched in ST_IDLE, its word loaded in ST_LOAD and shown in ST_EMIT.
// Throughput: one word per cycle while not stalled; 6 words for a byte request,
// 37 for the power-up sequence; next request taken the cycle after the last word.
// Reset: asynchronous, clears the sequencer and step counter; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module char_lcd_nibble_interface import clcd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   req_valid,
	output logic        req_stall,
	input  wire req_t   req,
	output logic        phase_valid,
	input  wire logic   phase_stall,
	output phase_t      phase
);

	ctl_cmd_t    cmd;
	ctl_status_t status;

	// Sequencer
	clcd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.phase_valid (phase_valid),
		.phase_stall (phase_stall),
		.cmd         (cmd),
		.status      (status)
	);

	// Request and word registers
	clcd_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.status (status),
		.phase  (phase)
	);

	// One request at a time
	`ASSERT_IMPL(a_busy_while_showing, phase_valid, req_stall,
		"request taken while a word is on show")
	// A new request shows nothing in the next cycle
	`ASSERT_NEXT(a_load_gap, req_valid && !req_stall, !phase_valid,
		"word shown straight after a request was taken")
	// No gap inside a request
	`ASSERT_NEXT(a_no_gap, phase_valid && !phase_stall && !phase.last_phase, phase_valid,
		"gap inside a run of words")
	// Release after the last word
	`ASSERT_NEXT(a_done_idle, phase_valid && !phase_stall && phase.last_phase,
		!phase_valid && !req_stall, "block not idle after the last word")

endmodule

`default_nettype wire

// File: verif/tb_char_lcd_nibble_interface.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_interface
// Self-checking bench for the 4-bit LCD driver. Request words go in and are
// expanded into the pin words they should produce. Each pin word that
// arrives is checked, field by field, against the oldest one still due. Both
// sides idle at random, and the run includes a long output hold-off and a
// full drain.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_char_lcd_nibble_interface;
	import clcd_pkg::*;

	// LCD timing and addressing, in ms and byte codes
	localparam logic [6:0] T_BASE     = 7'd1;
	localparam logic [6:0] T_POWER_UP = 7'd100;
	localparam logic [6:0] T_SETTLE   = 7'd10;
	localparam logic [6:0] T_SLOW     = 7'd4;
	localparam logic [6:0] T_FAST     = 7'd1;
	localparam logic [6:0] T_CHAR     = 7'd1;
	localparam logic [7:0] SLOW_BELOW = 8'h04;
	localparam logic [7:0] DDRAM_SET  = 8'h80;
	localparam logic [7:0] ROW_ADDR [4] = '{8'h00, 8'h40, 8'h10, 8'h50};
	localparam logic [7:0] BOOT_INSTR [4] = '{8'h28, 8'h08, 8'h01, 8'h06};
	localparam logic [3:0] BOOT_NIB [4] = '{4'h3, 4'h3, 4'h3, 4'h2};
	localparam logic [6:0] BOOT_NIB_WAIT [4] = '{7'd10, 7'd1, 7'd1, 7'd10};
	localparam logic RS_INSTR = 1'b0;
	localparam logic RS_CHAR  = 1'b1;

	localparam int RANDOM_REQS   = 100;
	localparam int HOLD_OFF_LEN  = 300;
	localparam int IDLE_PERCENT  = 13;

	// Pin words still due, built from each accepted request
	class phase_ledger;
		phase_t due_q[$];
		int     errors;

		function automatic logic [6:0] instr_wait(input logic [7:0] b);
			return (b < SLOW_BELOW) ? T_SLOW : T_FAST;
		endfunction

		function void add_phase(input logic [3:0] nib, input logic rs, input logic en,
				input logic [6:0] hold);
			phase_t p;
			p.data_nibble     = nib;
			p.register_select = rs;
			p.enable_pin      = en;
			p.hold_ms         = hold;
			p.last_phase      = 1'b0;
			due_q.push_back(p);
		endfunction

		// Setup, strobe, release; trailing wait goes on the release
		function void add_nibble(input logic [3:0] nib, input logic rs,
				input logic [6:0] extra);
			add_phase(nib, rs, 1'b0, T_BASE);
			add_phase(nib, rs, 1'b1, T_BASE);
			add_phase(nib, rs, 1'b0, 7'(T_BASE + extra));
		endfunction

		function void add_byte(input logic [7:0] b, input logic rs, input logic [6:0] extra);
			add_nibble(b[7:4], rs, 7'd0);
			add_nibble(b[3:0], rs, extra);
		endfunction

		function void note_request(input req_t r);
			logic [7:0] b;
			case (r.command)
				CMD_INIT: begin
					add_phase(4'h0, RS_INSTR, 1'b0, T_POWER_UP);
					for (int k = 0; k < 4; k++)
						add_nibble(BOOT_NIB[k], RS_INSTR, BOOT_NIB_WAIT[k]);
					for (int k = 0; k < 4; k++)
						add_byte(BOOT_INSTR[k], RS_INSTR,
							7'(instr_wait(BOOT_INSTR[k]) + T_SETTLE));
				end
				CMD_INSTR: add_byte(r.value_byte, RS_INSTR, instr_wait(r.value_byte));
				CMD_DATA:  add_byte(r.value_byte, RS_CHAR, T_CHAR);
				default: begin
					b = DDRAM_SET | ROW_ADDR[r.line_index];
					add_byte(b, RS_INSTR, instr_wait(b));
				end
			endcase
			due_q[$].last_phase = 1'b1;
		endfunction

		function void check_phase(input phase_t got);
			phase_t want;
			if (due_q.size() == 0) begin
				$error("unexpected pin word %h", got);
				errors++;
				return;
			end
			want = due_q.pop_front();
			if (got.data_nibble !== want.data_nibble) begin
				$error("data_nibble: expected %h, got %h", want.data_nibble, got.data_nibble);
				errors++;
			end
			if (got.register_select !== want.register_select) begin
				$error("register_select: expected %b, got %b",
					want.register_select, got.register_select);
				errors++;
			end
			if (got.enable_pin !== want.enable_pin) begin
				$error("enable_pin: expected %b, got %b", want.enable_pin, got.enable_pin);
				errors++;
			end
			if (got.hold_ms !== want.hold_ms) begin
				$error("hold_ms: expected %0d, got %0d", want.hold_ms, got.hold_ms);
				errors++;
			end
			if (got.last_phase !== want.last_phase) begin
				$error("last_phase: expected %b, got %b", want.last_phase, got.last_phase);
				errors++;
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   req_valid = 1'b0;
	logic   req_stall;
	req_t   req = '0;
	logic   phase_valid;
	logic   phase_stall = 1'b0;
	phase_t phase;

	// Owned by the stimulus process, read by the receiver
	logic   calm = 1'b0;
	logic   hold_off_req = 1'b0;

	phase_ledger phases_due = new();

	char_lcd_nibble_interface dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.phase_valid (phase_valid),
		.phase_stall (phase_stall),
		.phase       (phase)
	);

	always #5 clk = ~clk;

	// Check accepted pin words; stall at random or for the long hold-off
	int hold_left = 0;
	bit hold_off_taken = 1'b0;
	always @(posedge clk) begin
		if (arst_n && phase_valid && !phase_stall)
			phases_due.check_phase(phase);
		if (hold_off_req && !hold_off_taken) begin
			hold_off_taken = 1'b1;
			hold_left = HOLD_OFF_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			phase_stall <= 1'b1;
		end else begin
			phase_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Offer one request word, with random idle gaps, and hold it until taken
	task automatic send_request(input req_t r);
		while (!calm && ($urandom_range(99) < IDLE_PERCENT)) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		phases_due.note_request(r);
	endtask

	task automatic send_kind(input cmd_kind_t kind, input logic [7:0] b,
			input logic [1:0] row);
		req_t r;
		r.command    = kind;
		r.value_byte = b;
		r.line_index = row;
		send_request(r);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (phases_due.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		req_t r;
		int   pick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: power-up, slow/fast instruction boundary, byte extremes, every row
		send_kind(CMD_INIT, 8'hFF, 2'd3);
		send_kind(CMD_INSTR, 8'h00, 2'd3);
		send_kind(CMD_INSTR, 8'h01, 2'd0);
		send_kind(CMD_INSTR, 8'h03, 2'd2);
		send_kind(CMD_INSTR, 8'h04, 2'd1);
		send_kind(CMD_INSTR, 8'hFF, 2'd0);
		send_kind(CMD_DATA, 8'h00, 2'd3);
		send_kind(CMD_DATA, 8'hFF, 2'd0);
		send_kind(CMD_DATA, 8'hA5, 2'd1);
		send_kind(CMD_DATA, 8'h5A, 2'd2);
		for (int row = 0; row < 4; row++)
			send_kind(CMD_LINE, 8'($urandom_range(255)), 2'(row));
		send_kind(CMD_INIT, 8'h00, 2'd0);

		// Pause the sender until every pin word has come out
		wait_drained();

		// Random requests, mostly bytes; output held off early on, no idling while requests 50 to 74 go in
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i == 20)
				hold_off_req <= 1'b1;
			if (i == 50)
				calm <= 1'b1;
			if (i == 75)
				calm <= 1'b0;
			pick = $urandom_range(99);
			r.command    = (pick < 8)  ? CMD_INIT :
			               (pick < 38) ? CMD_INSTR :
			               (pick < 70) ? CMD_DATA : CMD_LINE;
			r.value_byte = 8'($urandom_range(255));
			r.line_index = 2'($urandom_range(3));
			send_request(r);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (phases_due.errors == 0 && phases_due.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Give up if the run hangs
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
